// ----- rtl/srtsch_pkg.sv -----
package srtsch_pkg;

  localparam int unsigned MAX_TASKS  = 16;
  localparam int unsigned TIME_WIDTH = 16;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot;
    logic        ran;
    logic        finished;
    logic        all_done;
    logic [31:0] current_time;
  } result_t;

  typedef struct packed {
    logic load;     // latch the accepted item and reset the tick search
    logic scan_rd;  // read the next table entry for the search
    logic update;   // apply the chosen task's unit of work and advance time
    logic emit;     // perform add or clear and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[3:0];
  endfunction

endpackage

// ----- rtl/srtsch_ctrl.sv -----
module srtsch_ctrl
  import srtsch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/srtsch_dp.sv -----
module srtsch_dp
  import srtsch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_data_o
);

  logic [15:0]           arr_mem [MAX_TASKS];
  logic [15:0]           rem_mem [MAX_TASKS];

  item_t                 item_q;
  logic [CNT_W-1:0]      task_count_q;
  logic [CNT_W-1:0]      done_count_q;
  logic [TIME_WIDTH-1:0] time_q;

  logic [IDX_W-1:0]      scan_idx_q;
  logic                  rd_pend_q;
  logic                  rd_in_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [15:0]           rd_arr_q;
  logic [15:0]           rd_rem_q;

  logic                  found_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [15:0]           best_rem_q;
  logic                  fin_q;

  logic                  out_valid_q;
  result_t               res_q;
  result_t               res_d;

  logic                  all_done;
  logic                  table_full;
  logic                  eligible;
  logic                  take;
  logic                  do_add;
  logic [IDX_W-1:0]      add_idx;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;

  assign all_done   = (done_count_q == task_count_q);
  assign table_full = (task_count_q == CNT_W'(MAX_TASKS));
  assign add_idx    = task_count_q[IDX_W-1:0];
  assign do_add     = cmd_i.emit && (item_q.operation == OP_ADD) && !table_full;

  assign status_o.need_scan = (in_data_i.operation == OP_TICK) && !all_done;
  assign status_o.scan_last = (scan_idx_q == IDX_W'(MAX_TASKS - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // Compare stage of the search, fed by the registered table read.
  assign eligible = rd_in_q && (32'(rd_arr_q) <= 32'(time_q)) && (rd_rem_q != 16'd0);
  assign take     = rd_pend_q && eligible && (!found_q || (rd_rem_q < best_rem_q));

  assign mem_we    = do_add || (cmd_i.update && found_q);
  assign mem_waddr = do_add ? add_idx : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rem_mem[mem_waddr] <= do_add ? item_q.burst_time : (best_rem_q - 16'd1);
    end
    if (do_add) begin
      arr_mem[mem_waddr] <= item_q.arrival_time;
    end
    if (cmd_i.scan_rd) begin
      rd_arr_q <= arr_mem[scan_idx_q];
      rd_rem_q <= rem_mem[scan_idx_q];
      rd_idx_q <= scan_idx_q;
      rd_in_q  <= (CNT_W'(scan_idx_q) < task_count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_rem_q <= rd_rem_q;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      done_count_q <= '0;
      time_q       <= '0;
      scan_idx_q   <= '0;
      rd_pend_q    <= 1'b0;
      found_q      <= 1'b0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_rd;

      if (cmd_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        fin_q      <= 1'b0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end

      if (take) begin
        found_q <= 1'b1;
      end

      if (cmd_i.update) begin
        if (found_q && (best_rem_q == 16'd1)) begin
          fin_q        <= 1'b1;
          done_count_q <= done_count_q + CNT_W'(1);
        end
        if (time_q != '1) begin
          time_q <= time_q + TIME_WIDTH'(1);
        end
      end

      if (do_add) begin
        task_count_q <= task_count_q + CNT_W'(1);
        if (item_q.burst_time == 16'd0) begin
          done_count_q <= done_count_q + CNT_W'(1);
        end
      end else if (cmd_i.emit && (item_q.operation == OP_CLEAR)) begin
        task_count_q <= '0;
        done_count_q <= '0;
        time_q       <= '0;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.all_done     = all_done;
    res_d.current_time = 32'(time_q);
    case (item_q.operation)
      OP_ADD: begin
        if (!table_full) begin
          res_d.accepted = 1'b1;
          res_d.slot     = to_slot(add_idx);
          // Counts after the add: a zero-length burst completes at once.
          res_d.all_done = (item_q.burst_time == 16'd0) && all_done;
        end
      end
      OP_TICK: begin
        res_d.accepted = 1'b1;
        res_d.ran      = found_q;
        res_d.finished = fin_q;
        res_d.slot     = found_q ? to_slot(best_idx_q) : 4'd0;
      end
      OP_CLEAR: begin
        res_d.accepted     = 1'b1;
        res_d.all_done     = 1'b1;
        res_d.current_time = '0;
      end
      default: begin
        res_d.accepted = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/srt_preemptive_scheduler_top.sv -----
// Preemptive shortest-remaining-time scheduler over a table of MAX_TASKS tasks.
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one operation per
// transaction: add a task, tick one time unit, or clear the table and time.
// Output channel (out_valid_o, out_stall_i, out_data_o) returns exactly one
// result transaction per input transaction, in order.
// Add, clear, unknown operations and ticks with nothing left to run go from
// acceptance straight to the finish state, which loads their result once the
// output register is free. A tick that searches the table passes through the
// scan, drain, update and finish states: the table memory has one read port, so
// the search reads all MAX_TASKS entries, one entry per cycle, then the drain
// state compares the last entry, the update state applies the update and the
// finish state loads the result.
// One item is in work at a time; in_stall_o is high from acceptance until the
// result is loaded into the output register. A new item is accepted while a
// finished result still waits there.
// When the receiver stalls, the result holds on out_data_o and a following
// item waits in its final cycle until the output register frees.
// Reset empties the table and zeroes time; no clearing pass is needed because
// slots at or above the task count are never used.
module srt_preemptive_scheduler_top
  import srtsch_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  srtsch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srtsch_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
